>>> src/bcl_pkg.sv
// Shared types and constants for the block buffer cache directory.
// No dependencies; imported by the controller, the datapath and the top level.
package bcl_pkg;

  localparam int unsigned DEF_ENTRIES = 32;

  // action codes
  localparam logic [1:0] ACT_GET     = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_PIN     = 2'd2;
  localparam logic [1:0] ACT_UNPIN   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOFREE    = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // one directory entry as held in the RAM
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic [31:0] stamp;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;     // capture request, clear scan results
    logic rd;      // issue a RAM read and step the address
    logic commit;  // write back and load the result register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;      // current read address is the last one for this request
    logic out_free;  // result register can take a new result this cycle
  } dp_sts_t;

endpackage

>>> src/bcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bcl_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bcl_ctrl.sv
// Request sequencer: accept, read sweep, settle, commit.
// Depends on bcl_pkg for the command and status structs.
module bcl_ctrl import bcl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output ctl_cmd_t cmd_o,
  input  dp_sts_t  sts_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        if (sts_i.last) begin
          state_d = S_WAIT;
        end
      end
      // last read data is evaluated here
      S_WAIT: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_cap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |=> (state_q == S_READ))
    else $error("capture did not start a read sweep");

  a_commit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !in_stall_o)
    else $error("controller not idle after commit");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.cap, cmd_o.rd, cmd_o.commit}))
    else $error("more than one command at once");

endmodule

>>> src/bcl_dp.sv
// Directory datapath: entry RAM, valid and written bits, scan accumulators,
// write-back and result register. Depends on bcl_pkg and bcl_ram.
module bcl_dp import bcl_pkg::*; #(
  parameter int unsigned ENTRIES = DEF_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    cmd_i,
  output dp_sts_t     sts_o,
  input  logic [1:0]  in_action_i,
  input  logic [7:0]  in_device_i,
  input  logic [31:0] in_block_number_i,
  input  logic [4:0]  in_entry_index_i,
  input  logic [31:0] in_tick_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  out_slot_o,
  output logic        out_hit_o,
  output logic        out_needs_fill_o,
  output logic [1:0]  out_status_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(ENTRIES - 1);

  // request
  logic [1:0]  act_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  logic [4:0]  idx_q;
  logic [31:0] now_q;
  logic        idx_ok_q;

  logic [IDX_W-1:0] addr_q;
  logic [8:0]       in_idx_w;

  // entry flags: written since reset, and the valid mark
  logic [ENTRIES-1:0] init_q;
  logic [ENTRIES-1:0] vld_q;

  // read data in flight
  logic             ev_q;
  logic [IDX_W-1:0] ev_addr_q;
  logic             ev_init_q;
  logic             ev_vld_q;
  logic [$bits(entry_t)-1:0] rd_data;
  entry_t           ev_word;

  // scan accumulators
  logic             mfound_q;
  logic [IDX_W-1:0] m_idx_q;
  entry_t           m_word_q;
  logic             m_vld_q;
  logic             ffound_q;
  logic [IDX_W-1:0] f_idx_q;
  logic [31:0]      f_stamp_q;
  logic             sel_match;
  logic             sel_free;

  // write-back and result
  logic             wr_en;
  logic             set_vld;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_word;
  logic [4:0]       res_slot;
  logic             res_hit;
  logic             res_fill;
  logic [1:0]       res_status;
  logic [7:0]       m_cnt_inc;

  logic       out_valid_q;
  logic [4:0] out_slot_q;
  logic       out_hit_q;
  logic       out_fill_q;
  logic [1:0] out_status_q;

  assign in_idx_w = {4'b0, in_entry_index_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      act_q    <= in_action_i;
      dev_q    <= in_device_i;
      blk_q    <= in_block_number_i;
      idx_q    <= in_entry_index_i;
      now_q    <= in_tick_now_i;
      idx_ok_q <= (in_idx_w < 9'(ENTRIES));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      addr_q <= (in_action_i == ACT_GET) ? '0 : in_idx_w[IDX_W-1:0];
    end else if (cmd_i.rd) begin
      addr_q <= addr_q + 1'b1;
    end
  end

  assign sts_o.last     = (act_q != ACT_GET) || (addr_q == LAST_ADDR);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  bcl_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_word),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
    end else begin
      ev_q <= cmd_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      ev_addr_q <= addr_q;
      ev_init_q <= init_q[addr_q];
      ev_vld_q  <= vld_q[addr_q];
    end
  end

  // an entry never written reads as all zero
  assign ev_word = ev_init_q ? entry_t'(rd_data) : '0;

  // non-get requests read only the addressed entry and take it as the match
  assign sel_match = ev_q && !mfound_q &&
                     ((act_q != ACT_GET) ||
                      (ev_word.dev == dev_q && ev_word.blk == blk_q));
  assign sel_free  = ev_q && (ev_word.cnt == 8'd0) &&
                     (!ffound_q || (ev_word.stamp < f_stamp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mfound_q <= 1'b0;
      ffound_q <= 1'b0;
    end else if (cmd_i.cap) begin
      mfound_q <= 1'b0;
      ffound_q <= 1'b0;
    end else begin
      if (sel_match) begin
        mfound_q <= 1'b1;
      end
      if (sel_free) begin
        ffound_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_match) begin
      m_idx_q  <= ev_addr_q;
      m_word_q <= ev_word;
      m_vld_q  <= ev_vld_q;
    end
    if (sel_free) begin
      f_idx_q   <= ev_addr_q;
      f_stamp_q <= ev_word.stamp;
    end
  end

  assign m_cnt_inc = (m_word_q.cnt == 8'hFF) ? m_word_q.cnt : m_word_q.cnt + 8'd1;

  always_comb begin
    wr_en      = 1'b0;
    set_vld    = 1'b0;
    wr_addr    = m_idx_q;
    wr_word    = m_word_q;
    res_slot   = idx_q;
    res_hit    = 1'b0;
    res_fill   = 1'b0;
    res_status = ST_OK;
    if (act_q == ACT_GET) begin
      if (mfound_q) begin
        wr_en       = 1'b1;
        set_vld     = 1'b1;
        wr_word.cnt = m_cnt_inc;
        res_slot    = 5'(9'(m_idx_q));
        res_hit     = 1'b1;
        res_fill    = !m_vld_q;
      end else if (ffound_q) begin
        wr_en    = 1'b1;
        set_vld  = 1'b1;
        wr_addr  = f_idx_q;
        wr_word  = '{dev: dev_q, blk: blk_q, cnt: 8'd1, stamp: f_stamp_q};
        res_slot = 5'(9'(f_idx_q));
        res_fill = 1'b1;
      end else begin
        res_slot   = '0;
        res_status = ST_NOFREE;
      end
    end else if (idx_ok_q) begin
      if (act_q == ACT_PIN) begin
        wr_en       = 1'b1;
        wr_word.cnt = m_cnt_inc;
      end else if (m_word_q.cnt == 8'd0) begin
        res_status = ST_UNDERFLOW;
      end else begin
        wr_en       = 1'b1;
        wr_word.cnt = m_word_q.cnt - 8'd1;
        // only a release to zero refreshes the stamp
        if (act_q == ACT_RELEASE && m_word_q.cnt == 8'd1) begin
          wr_word.stamp = now_q;
        end
      end
    end
    if (!cmd_i.commit) begin
      wr_en   = 1'b0;
      set_vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      vld_q  <= '0;
    end else begin
      if (wr_en) begin
        init_q[wr_addr] <= 1'b1;
      end
      if (set_vld) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_slot_q   <= res_slot;
      out_hit_q    <= res_hit;
      out_fill_q   <= res_fill;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_slot_o       = out_slot_q;
  assign out_hit_o        = out_hit_q;
  assign out_needs_fill_o = out_fill_q;
  assign out_status_o     = out_status_q;

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_commit_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !ev_q)
    else $error("commit with read data still in flight");

  a_write_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> cmd_i.commit && (act_q != ACT_GET || mfound_q || ffound_q))
    else $error("RAM write outside a commit");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_hit_q |-> out_status_q == ST_OK)
    else $error("hit reported with error status");

  a_nofree_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == ST_NOFREE |->
      !out_hit_q && !out_fill_q && out_slot_q == 5'd0)
    else $error("no-free result carries payload");

endmodule

>>> src/block_buffer_cache_lru.sv
// Block buffer cache directory with reference counts and LRU replacement.
// Request channel (in_*) and result channel (out_*) use valid/stall: a
// transfer happens at a rising edge with valid high and stall low.
// Every request transfer gives exactly one result transfer, in order.
// Actions: get looks up (device, block_number); on a miss it claims the
// free entry with the oldest release stamp. Release, pin and unpin adjust
// the count of the entry named by entry_index.
// A get sweeps every entry: the entry RAM has one read port and is swept
// one entry per cycle. Release, pin and unpin read only the entry named
// by entry_index. A new request is taken once the previous one has
// committed, even while its result still waits.
// When out_stall_i holds the result, the result register keeps it and the
// next request stops before commit until the register is free.
// Reset clears all control and marks every entry as zero (tags, count,
// stamp); no clearing pass is needed.
// Depends on bcl_pkg, bcl_ctrl, bcl_dp and bcl_ram.
module block_buffer_cache_lru import bcl_pkg::*; #(
  parameter int unsigned ENTRIES = DEF_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_action_i,
  input  logic [7:0]  in_device_i,
  input  logic [31:0] in_block_number_i,
  input  logic [4:0]  in_entry_index_i,
  input  logic [31:0] in_tick_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  out_slot_o,
  output logic        out_hit_o,
  output logic        out_needs_fill_o,
  output logic [1:0]  out_status_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bcl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_action_i       (in_action_i),
    .in_device_i       (in_device_i),
    .in_block_number_i (in_block_number_i),
    .in_entry_index_i  (in_entry_index_i),
    .in_tick_now_i     (in_tick_now_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_slot_o        (out_slot_o),
    .out_hit_o         (out_hit_o),
    .out_needs_fill_o  (out_needs_fill_o),
    .out_status_o      (out_status_o)
  );

endmodule
